// File: hw/rtl/sfg_pkg.sv
package sfg_pkg;

    localparam int STROKE_DEPTH_DEF = 4096;
    localparam int MAX_STROKES_DEF  = 64;
    localparam int CHAR_COUNT_DEF   = 256;

    localparam int COORD_W   = 32;
    localparam int SCALE_W   = 16;
    localparam int TRIG_W    = 16;
    localparam int PT_W      = 8;
    localparam int KIND_W    = 2;
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 12;
    localparam int OFFS_W    = 12;
    localparam int CHAR_W    = 8;
    localparam int ENTRY_W   = KIND_W + 2 * PT_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Operand widths of the shared dot-product unit. The coefficient holds
    // scale * cos or scale * sin, which is held in 33 signed bits.
    localparam int OP_A_W    = SCALE_W + 1;
    localparam int COEF_W    = SCALE_W + TRIG_W + 1;
    localparam int DOT_W     = OP_A_W + COEF_W + 1;
    localparam int ROT_SHIFT = 14;

    localparam logic [DOT_W-1:0]   ROUND_BIAS = DOT_W'(1) << (ROT_SHIFT - 1);
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
    localparam logic [TRIG_W-1:0]  COS_RESET   = 16'd16384;
    localparam logic [TRIG_W-1:0]  SIN_RESET   = 16'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_STROKE = 2'd0,
        CMD_LOAD_OFFSET = 2'd1,
        CMD_DRAW        = 2'd2,
        CMD_SET_ORIGIN  = 2'd3
    } cmd_t;

    localparam logic [KIND_W-1:0] KIND_END  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIN   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFFS,
        ST_COEF_A,
        ST_COEF_B,
        ST_DECODE,
        ST_ROT_Y,
        ST_APPLY,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic signed [OP_A_W-1:0] a0;
        logic signed [COEF_W-1:0] b0;
        logic signed [OP_A_W-1:0] a1;
        logic signed [COEF_W-1:0] b1;
        logic                     rnd;
    } dot_op_t;

    typedef struct packed {
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
    } seg_t;

endpackage

// File: hw/rtl/sfg_dot.sv
module sfg_dot (
    input  logic                             aclk,
    input  sfg_pkg::dot_op_t                 op,
    output logic signed [sfg_pkg::DOT_W-1:0] q
);
    import sfg_pkg::*;

    logic signed [DOT_W-1:0] a0_ext;
    logic signed [DOT_W-1:0] b0_ext;
    logic signed [DOT_W-1:0] a1_ext;
    logic signed [DOT_W-1:0] b1_ext;
    logic signed [DOT_W-1:0] p0;
    logic signed [DOT_W-1:0] p1;
    logic signed [DOT_W-1:0] bias;

    always_comb begin
        a0_ext = DOT_W'($signed(op.a0));
        b0_ext = DOT_W'($signed(op.b0));
        a1_ext = DOT_W'($signed(op.a1));
        b1_ext = DOT_W'($signed(op.b1));
        p0     = a0_ext * b0_ext;
        p1     = a1_ext * b1_ext;
        bias   = op.rnd ? $signed(ROUND_BIAS) : '0;
    end

    // The rounding constant rides along in the final add, so the caller
    // only has to take the shifted field of q.
    always_ff @(posedge aclk) begin
        q <= p0 + p1 + bias;
    end

endmodule

// File: hw/rtl/stroke_font_glyph_renderer_top.sv
// Load stroke, load offset and set origin transactions are taken while idle and leave the block idle.
// A draw reads the offset, forms scale*cos and scale*sin, then decodes, rotates and applies
// each stroke (at most MAX_STROKES) through the shared dot-product unit, and closes with a flush.
// A segment stalls the walk only while the previous one still waits at m_.
// Reset is synchronous and active low: scale, angle and origin return to their
// defaults, the stroke store and offset table are not cleared.
module stroke_font_glyph_renderer_top #(
    parameter int STROKE_DEPTH = sfg_pkg::STROKE_DEPTH_DEF,
    parameter int MAX_STROKES  = sfg_pkg::MAX_STROKES_DEF,
    parameter int CHAR_COUNT   = sfg_pkg::CHAR_COUNT_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic [sfg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sfg_pkg::CFG_W-1:0]             cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [sfg_pkg::CMD_W-1:0]             s_cmd,
    input  logic [sfg_pkg::INDEX_W-1:0]           s_index,
    input  logic [sfg_pkg::KIND_W-1:0]            s_stroke_kind,
    input  logic signed [sfg_pkg::PT_W-1:0]       s_point_x,
    input  logic signed [sfg_pkg::PT_W-1:0]       s_point_y,
    input  logic [sfg_pkg::OFFS_W-1:0]            s_offset_value,
    input  logic [sfg_pkg::CHAR_W-1:0]            s_char_code,
    input  logic signed [sfg_pkg::COORD_W-1:0]    s_start_x,
    input  logic signed [sfg_pkg::COORD_W-1:0]    s_start_y,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [sfg_pkg::COORD_W-1:0]    m_from_x,
    output logic signed [sfg_pkg::COORD_W-1:0]    m_from_y,
    output logic signed [sfg_pkg::COORD_W-1:0]    m_to_x,
    output logic signed [sfg_pkg::COORD_W-1:0]    m_to_y,
    output logic                                  m_last,
    output logic                                  m_truncated
);
    import sfg_pkg::*;

    // The stroke store depth is a power of two, so addresses wrap by truncation.
    localparam int AW  = $clog2(STROKE_DEPTH);
    localparam int CHW = $clog2(CHAR_COUNT);
    localparam int CW  = $clog2(MAX_STROKES);

    state_t state_reg, state_next;

    logic [SCALE_W-1:0]        scale_reg;
    logic [TRIG_W-1:0]         cos_reg;
    logic [TRIG_W-1:0]         sin_reg;
    logic [COORD_W-1:0]        origin_x_reg;
    logic [COORD_W-1:0]        origin_y_reg;
    logic [COORD_W-1:0]        pen_x_reg;
    logic [COORD_W-1:0]        pen_y_reg;
    logic [COORD_W-1:0]        rx_reg;
    logic signed [COEF_W-1:0]  coef_a_reg;
    logic signed [COEF_W-1:0]  coef_b_reg;
    logic signed [COEF_W-1:0]  coef_nb_reg;
    logic [AW-1:0]             addr_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      ended_reg;
    logic [ENTRY_W-1:0]        stroke_q_reg;
    logic [OFFS_W-1:0]         offs_q_reg;
    seg_t                      pend_reg;
    logic                      pend_valid_reg;
    seg_t                      out_seg_reg;
    logic                      out_last_reg;
    logic                      out_trunc_reg;
    logic                      out_valid_reg;

    logic [ENTRY_W-1:0]        stroke_mem [0:STROKE_DEPTH-1];
    logic [OFFS_W-1:0]         offset_mem [0:CHAR_COUNT-1];

    dot_op_t                   dot_op;
    logic signed [DOT_W-1:0]   dot_q;

    logic                      accept;
    cmd_t                      cmd;
    logic                      draw_ok;
    logic                      offs_ok;
    logic [KIND_W-1:0]         kind;
    logic [PT_W-1:0]           pt_x;
    logic [PT_W-1:0]           pt_y;
    logic [AW-1:0]             addr_inc;
    logic                      last_step;
    logic                      out_free;
    logic                      apply_stall;
    logic                      apply_go;
    logic                      flush_go;
    logic                      out_load;
    logic                      stroke_rd_en;
    logic [AW-1:0]             stroke_rd_addr;
    logic [COORD_W-1:0]        rot_res;
    logic [COORD_W-1:0]        ry_abs;

    sfg_dot u_dot (
        .aclk (aclk),
        .op   (dot_op),
        .q    (dot_q)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = out_valid_reg;
    assign m_from_x    = out_seg_reg.from_x;
    assign m_from_y    = out_seg_reg.from_y;
    assign m_to_x      = out_seg_reg.to_x;
    assign m_to_y      = out_seg_reg.to_y;
    assign m_last      = out_last_reg;
    assign m_truncated = out_trunc_reg;

    always_comb begin
        accept      = s_valid && s_ready;
        cmd         = cmd_t'(s_cmd);
        draw_ok     = {1'b0, s_char_code} < 9'(CHAR_COUNT);
        offs_ok     = s_index < INDEX_W'(CHAR_COUNT);
        kind        = stroke_q_reg[ENTRY_W-1 -: KIND_W];
        pt_x        = stroke_q_reg[2*PT_W-1 -: PT_W];
        pt_y        = stroke_q_reg[PT_W-1:0];
        addr_inc    = addr_reg + AW'(1);
        last_step   = (cnt_reg == CW'(MAX_STROKES - 1));
        out_free    = !out_valid_reg || m_ready;
        rot_res     = dot_q[ROT_SHIFT +: COORD_W];
        ry_abs      = origin_y_reg + rot_res;

        apply_stall = (state_reg == ST_APPLY) && (kind == KIND_LINE) &&
                      pend_valid_reg && !out_free;
        apply_go    = (state_reg == ST_APPLY) && !apply_stall;
        flush_go    = (state_reg == ST_FLUSH) && (!pend_valid_reg || out_free);
        out_load    = (apply_go && (kind == KIND_LINE) && pend_valid_reg) ||
                      (flush_go && pend_valid_reg);

        stroke_rd_en   = (state_reg == ST_COEF_B) || (apply_go && !last_step);
        stroke_rd_addr = (state_reg == ST_APPLY) ? addr_inc : addr_reg;

        // Default operation produces the rotated x: x * (s*cos) + y * (-s*sin).
        dot_op.a0  = {{(OP_A_W-PT_W){pt_x[PT_W-1]}}, pt_x};
        dot_op.b0  = coef_a_reg;
        dot_op.a1  = {{(OP_A_W-PT_W){pt_y[PT_W-1]}}, pt_y};
        dot_op.b1  = coef_nb_reg;
        dot_op.rnd = 1'b1;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (cmd == CMD_DRAW) && draw_ok) begin
                    state_next = ST_OFFS;
                end
            end
            ST_OFFS: begin
                dot_op.a0  = {1'b0, scale_reg};
                dot_op.b0  = {{(COEF_W-TRIG_W){cos_reg[TRIG_W-1]}}, cos_reg};
                dot_op.a1  = '0;
                dot_op.b1  = '0;
                dot_op.rnd = 1'b0;
                state_next = ST_COEF_A;
            end
            ST_COEF_A: begin
                dot_op.a0  = {1'b0, scale_reg};
                dot_op.b0  = {{(COEF_W-TRIG_W){sin_reg[TRIG_W-1]}}, sin_reg};
                dot_op.a1  = '0;
                dot_op.b1  = '0;
                dot_op.rnd = 1'b0;
                state_next = ST_COEF_B;
            end
            ST_COEF_B: begin
                state_next = ST_DECODE;
            end
            ST_DECODE: begin
                state_next = (kind == KIND_END) ? ST_FLUSH : ST_ROT_Y;
            end
            ST_ROT_Y, ST_APPLY: begin
                // Held through a stall so the y result stays in the unit.
                dot_op.b0 = coef_b_reg;
                dot_op.b1 = coef_a_reg;
                if (state_reg == ST_ROT_Y) begin
                    state_next = ST_APPLY;
                end else if (apply_go) begin
                    state_next = last_step ? ST_FLUSH : ST_DECODE;
                end
            end
            ST_FLUSH: begin
                if (flush_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (cmd == CMD_LOAD_STROKE)) begin
            stroke_mem[AW'(s_index)] <= {s_stroke_kind, s_point_x, s_point_y};
        end
        if (stroke_rd_en) begin
            stroke_q_reg <= stroke_mem[stroke_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (cmd == CMD_LOAD_OFFSET) && offs_ok) begin
            offset_mem[CHW'(s_index)] <= s_offset_value;
        end
        if (accept && (cmd == CMD_DRAW) && draw_ok) begin
            offs_q_reg <= offset_mem[CHW'(s_char_code)];
        end
    end

    // Control state, configuration and origin.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg      <= SCALE_RESET;
            cos_reg        <= COS_RESET;
            sin_reg        <= SIN_RESET;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            ended_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SCALE: scale_reg <= cfg_wdata;
                    REG_COS:   cos_reg   <= cfg_wdata;
                    REG_SIN:   sin_reg   <= cfg_wdata;
                    default: ;
                endcase
            end

            if (accept && (cmd == CMD_SET_ORIGIN)) begin
                origin_x_reg <= s_start_x;
                origin_y_reg <= s_start_y;
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if ((state_reg == ST_IDLE) && (state_next == ST_OFFS)) begin
                cnt_reg   <= '0;
                ended_reg <= 1'b0;
            end
            if ((state_reg == ST_DECODE) && (kind == KIND_END)) begin
                ended_reg <= 1'b1;
            end
            if (apply_go) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (kind == KIND_LINE) begin
                    pend_valid_reg <= 1'b1;
                end
            end
            // The pen is kept in absolute coordinates, so the new origin is
            // simply the final pen position.
            if (flush_go) begin
                pend_valid_reg <= 1'b0;
                origin_x_reg   <= pen_x_reg;
                origin_y_reg   <= pen_y_reg;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && (state_next == ST_OFFS)) begin
            pen_x_reg <= origin_x_reg;
            pen_y_reg <= origin_y_reg;
        end
        if (state_reg == ST_OFFS) begin
            addr_reg <= AW'(offs_q_reg);
        end
        if (state_reg == ST_COEF_A) begin
            coef_a_reg <= dot_q[COEF_W-1:0];
        end
        if (state_reg == ST_COEF_B) begin
            coef_b_reg  <= dot_q[COEF_W-1:0];
            coef_nb_reg <= -dot_q[COEF_W-1:0];
        end
        if (state_reg == ST_ROT_Y) begin
            rx_reg <= origin_x_reg + rot_res;
        end
        if (apply_go) begin
            addr_reg <= addr_inc;
            if ((kind == KIND_MOVE) || (kind == KIND_LINE)) begin
                pen_x_reg <= rx_reg;
                pen_y_reg <= ry_abs;
            end
            if (kind == KIND_LINE) begin
                pend_reg.from_x <= pen_x_reg;
                pend_reg.from_y <= pen_y_reg;
                pend_reg.to_x   <= rx_reg;
                pend_reg.to_y   <= ry_abs;
            end
        end
        if (out_load) begin
            out_seg_reg   <= pend_reg;
            out_last_reg  <= (state_reg == ST_FLUSH);
            out_trunc_reg <= (state_reg == ST_FLUSH) && !ended_reg;
        end
    end

endmodule

// File: hw/rtl/sfg_checker.sv
module sfg_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [sfg_pkg::CMD_W-1:0]         s_cmd,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [sfg_pkg::COORD_W-1:0] m_from_x,
    input logic                              m_last,
    input logic                              m_truncated
);
    import sfg_pkg::*;

    // Only the final segment of a character can report a cut-off walk.
    a_trunc_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_last)
        else $error("truncated set on a segment that is not last");

    // While a segment waits, it does not change.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_from_x) && $stable(m_last))
        else $error("waiting segment changed");

    // Load and origin transactions never make the block busy.
    a_load_no_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && ((s_cmd == CMD_LOAD_STROKE) ||
        (s_cmd == CMD_LOAD_OFFSET) || (s_cmd == CMD_SET_ORIGIN)) |=> s_ready)
        else $error("busy after a load transaction");

    // A segment only appears out of a draw in progress.
    a_seg_from_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("segment produced while idle");

    // A draw is not over while one of its inner segments is still pending.
    a_inner_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("idle with an unfinished character");

endmodule

bind stroke_font_glyph_renderer_top sfg_checker u_sfg_checker (.*);

// File: verif/stroke_font_glyph_renderer_top_tb.sv
`timescale 1ns / 1ps

module stroke_font_glyph_renderer_top_tb;
    import sfg_pkg::*;

    localparam int STROKES     = STROKE_DEPTH_DEF;
    localparam int WALK_MAX    = MAX_STROKES_DEF;
    localparam int CHARS       = CHAR_COUNT_DEF;
    localparam int DRAW_CYCLES = 4 + 3 * WALK_MAX + 1 + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 60;
    localparam int N_DIRECTED  = 23;
    localparam int MAX_REPORTS = 10;

    localparam logic [KIND_W-1:0] KIND_SKIP = 2'd3;

    typedef struct packed {
        cmd_t                      cmd;
        logic [INDEX_W-1:0]        index;
        logic [KIND_W-1:0]         kind;
        logic signed [PT_W-1:0]    px;
        logic signed [PT_W-1:0]    py;
        logic [OFFS_W-1:0]         offs;
        logic [CHAR_W-1:0]         ch;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
    } glyph_cmd_t;

    typedef struct packed {
        seg_t pos;
        logic last;
        logic trunc;
    } segment_t;

    typedef struct packed {
        glyph_cmd_t c;
        logic       pinned;
        segment_t   want;
    } step_row_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
    } stroke_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } vec_t;

    localparam segment_t NO_SEG = '0;
    // Unit scale, zero angle: point (1, 2) lands at (256, 512) from the origin.
    localparam segment_t ORIGIN_SEG = '{'{32'd0, 32'd0, 32'd256, 32'd512}, 1'b1, 1'b0};
    // Origin at the coordinate extremes, so the segment end wraps around.
    localparam segment_t WRAP_SEG =
        '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_7EFF, 32'h7FFF_8000}, 1'b1, 1'b0};

    // cmd, index, kind, x, y, offset, char, origin x, origin y | pinned, result
    localparam step_row_t DIRECTED [N_DIRECTED] = '{
        '{'{CMD_LOAD_STROKE, 12'd0, KIND_LINE, 8'h01, 8'h02, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_STROKE, 12'd1, KIND_END, 8'h00, 8'h00, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_OFFSET, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_DRAW, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b1, ORIGIN_SEG},
        '{'{CMD_SET_ORIGIN, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd0,
            32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, NO_SEG},
        '{'{CMD_LOAD_STROKE, 12'd2, KIND_LINE, 8'h7F, 8'h80, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_STROKE, 12'd3, KIND_END, 8'h00, 8'h00, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_OFFSET, 12'd255, KIND_END, 8'h00, 8'h00, 12'd2, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_DRAW, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd255, 32'd0, 32'd0},
          1'b1, WRAP_SEG},
        '{'{CMD_LOAD_STROKE, 12'd4095, KIND_SKIP, 8'h80, 8'h7F, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_STROKE, 12'd4094, KIND_MOVE, 8'h80, 8'h7F, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_OFFSET, 12'd1, KIND_END, 8'h00, 8'h00, 12'd4094, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_DRAW, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd1, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_OFFSET, 12'd4095, KIND_END, 8'h00, 8'h00, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_DRAW, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd1, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_STROKE, 12'd8, KIND_MOVE, 8'h05, 8'hFB, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_STROKE, 12'd9, KIND_END, 8'h00, 8'h00, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_LOAD_OFFSET, 12'd2, KIND_END, 8'h00, 8'h00, 12'd8, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_DRAW, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd2, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_SET_ORIGIN, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_DRAW, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd0, 32'd0, 32'd0},
          1'b1, ORIGIN_SEG},
        '{'{CMD_LOAD_OFFSET, 12'd3, KIND_END, 8'h00, 8'h00, 12'd1, 8'd0, 32'd0, 32'd0},
          1'b0, NO_SEG},
        '{'{CMD_DRAW, 12'd0, KIND_END, 8'h00, 8'h00, 12'd0, 8'd3, 32'd0, 32'd0},
          1'b0, NO_SEG}
    };

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [CFG_W-1:0]          cfg_wdata      = '0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [CMD_W-1:0]          s_cmd          = '0;
    logic [INDEX_W-1:0]        s_index        = '0;
    logic [KIND_W-1:0]         s_stroke_kind  = '0;
    logic signed [PT_W-1:0]    s_point_x      = '0;
    logic signed [PT_W-1:0]    s_point_y      = '0;
    logic [OFFS_W-1:0]         s_offset_value = '0;
    logic [CHAR_W-1:0]         s_char_code    = '0;
    logic signed [COORD_W-1:0] s_start_x      = '0;
    logic signed [COORD_W-1:0] s_start_y      = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic signed [COORD_W-1:0] m_from_x;
    logic signed [COORD_W-1:0] m_from_y;
    logic signed [COORD_W-1:0] m_to_x;
    logic signed [COORD_W-1:0] m_to_y;
    logic                      m_last;
    logic                      m_truncated;

    // Shadow of the block's state and registers.
    stroke_t                  font_strokes [STROKES];
    bit                       stroke_known [STROKES];
    logic [OFFS_W-1:0]        glyph_offsets [CHARS];
    bit                       offset_known [CHARS];
    logic [COORD_W-1:0]       org_x, org_y, pen_x, pen_y;
    logic [SCALE_W-1:0]       scale_r;
    logic signed [TRIG_W-1:0] cos_r, sin_r;

    segment_t    pending_segs[$];
    logic [7:0]  defined_chars[$];

    bit  idle_on  = 1'b0;
    bit  hold_req = 1'b0;
    int  mismatches, seg_count, trunc_seen, accepted_items, ignored_items;
    int  draw_count, settings_used, cycles;

    stroke_font_glyph_renderer_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_index        (s_index),
        .s_stroke_kind  (s_stroke_kind),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .s_offset_value (s_offset_value),
        .s_char_code    (s_char_code),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_from_x       (m_from_x),
        .m_from_y       (m_from_y),
        .m_to_x         (m_to_x),
        .m_to_y         (m_to_y),
        .m_last         (m_last),
        .m_truncated    (m_truncated)
    );

    always #2 aclk = ~aclk;

    // Scale, then rotate with rounding half up on the Q1.14 product.
    function automatic vec_t rotate_point(logic signed [PT_W-1:0] px,
                                          logic signed [PT_W-1:0] py);
        longint sx, sy, vx, vy;
        vec_t   r;
        sx = longint'(px) * longint'(scale_r);
        sy = longint'(py) * longint'(scale_r);
        vx = sx * longint'(cos_r) - sy * longint'(sin_r);
        vy = sx * longint'(sin_r) + sy * longint'(cos_r);
        r.x = COORD_W'((vx + 64'sd8192) >>> 14);
        r.y = COORD_W'((vy + 64'sd8192) >>> 14);
        return r;
    endfunction

    // A draw may only walk entries that were loaded before.
    function automatic bit walk_is_loaded(logic [CHAR_W-1:0] ch);
        logic [INDEX_W-1:0] addr;
        if (!offset_known[ch])
            return 1'b0;
        addr = glyph_offsets[ch];
        for (int j = 0; j < WALK_MAX; j++) begin
            if (!stroke_known[addr])
                return 1'b0;
            if (font_strokes[addr].kind == KIND_END)
                return 1'b1;
            addr = addr + 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic trace_glyph(logic [CHAR_W-1:0] ch, bit queue_it);
        segment_t           segs[$];
        segment_t           sg;
        logic [INDEX_W-1:0] addr;
        stroke_t            e;
        vec_t               p;
        bit                 ended;
        ended = 1'b0;
        addr  = glyph_offsets[ch];
        for (int j = 0; j < WALK_MAX; j++) begin
            e = font_strokes[addr];
            if (e.kind == KIND_END) begin
                ended = 1'b1;
                break;
            end
            p = rotate_point(e.x, e.y);
            if (e.kind == KIND_LINE) begin
                sg = '{'{org_x + pen_x, org_y + pen_y, org_x + p.x, org_y + p.y}, 1'b0, 1'b0};
                segs.push_back(sg);
            end
            if (e.kind == KIND_MOVE || e.kind == KIND_LINE) begin
                pen_x = p.x;
                pen_y = p.y;
            end
            addr = addr + 1'b1;
        end
        if (segs.size() > 0) begin
            segs[segs.size() - 1].last  = 1'b1;
            segs[segs.size() - 1].trunc = !ended;
        end
        if (queue_it)
            foreach (segs[k])
                pending_segs.push_back(segs[k]);
        org_x = org_x + pen_x;
        org_y = org_y + pen_y;
        pen_x = '0;
        pen_y = '0;
    endtask

    task automatic apply_cmd(glyph_cmd_t c, bit queue_it);
        case (c.cmd)
            CMD_LOAD_STROKE: begin
                font_strokes[c.index] = '{c.kind, c.px, c.py};
                stroke_known[c.index] = 1'b1;
            end
            CMD_LOAD_OFFSET: begin
                if (c.index < CHARS) begin
                    glyph_offsets[c.index] = c.offs;
                    offset_known[c.index]  = 1'b1;
                end
            end
            CMD_DRAW: begin
                draw_count++;
                trace_glyph(c.ch, queue_it);
            end
            default: begin
                org_x = c.ox;
                org_y = c.oy;
                pen_x = '0;
                pen_y = '0;
            end
        endcase
    endtask

    task automatic issue(glyph_cmd_t c, bit pinned = 1'b0, segment_t want = '0);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= c.cmd;
        s_index        <= c.index;
        s_stroke_kind  <= c.kind;
        s_point_x      <= c.px;
        s_point_y      <= c.py;
        s_offset_value <= c.offs;
        s_char_code    <= c.ch;
        s_start_x      <= c.ox;
        s_start_y      <= c.oy;
        do @(posedge aclk); while (!s_ready);
        accepted_items++;
        if (c.cmd == CMD_LOAD_OFFSET && c.index >= CHARS)
            ignored_items++;
        apply_cmd(c, !pinned);
        if (pinned)
            pending_segs.push_back(want);
    endtask

    // Every field random; callers override the ones that matter.
    function automatic glyph_cmd_t noise_cmd();
        glyph_cmd_t c;
        c.cmd   = cmd_t'($urandom_range(0, 3));
        c.index = INDEX_W'($urandom());
        c.kind  = KIND_W'($urandom());
        c.px    = PT_W'($urandom());
        c.py    = PT_W'($urandom());
        c.offs  = OFFS_W'($urandom());
        c.ch    = CHAR_W'($urandom());
        c.ox    = $urandom();
        c.oy    = $urandom();
        return c;
    endfunction

    task automatic move_origin();
        glyph_cmd_t c;
        c     = noise_cmd();
        c.cmd = CMD_SET_ORIGIN;
        case ($urandom_range(0, 5))
            0: c.ox = 32'h7FFF_FFFF;
            1: c.oy = 32'h8000_0000;
            2: c.ox = 32'hFFFF_FF00;
            default: ;
        endcase
        issue(c);
    endtask

    task automatic draw_char(logic [CHAR_W-1:0] ch);
        glyph_cmd_t c;
        c     = noise_cmd();
        c.cmd = CMD_DRAW;
        c.ch  = ch;
        issue(c);
    endtask

    // Load a glyph, point a character at it and draw it. A run-off glyph has
    // no end mark within the walk bound, so its last segment is truncated.
    task automatic glyph_seq(int len, bit all_lines, bit run_off);
        glyph_cmd_t         c;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] base;
        int                 w, draws;
        ch   = CHAR_W'($urandom());
        base = INDEX_W'($urandom());
        for (int k = 0; k <= len; k++) begin
            if (k == len && run_off)
                break;
            c       = noise_cmd();
            c.cmd   = CMD_LOAD_STROKE;
            c.index = base + INDEX_W'(k);
            w       = $urandom_range(0, 9);
            if (k == len)
                c.kind = KIND_END;
            else if (all_lines || w < 6)
                c.kind = KIND_LINE;
            else if (w < 9)
                c.kind = KIND_MOVE;
            else
                c.kind = KIND_SKIP;
            issue(c);
        end
        if ($urandom_range(0, 3) == 0)
            move_origin();
        c       = noise_cmd();
        c.cmd   = CMD_LOAD_OFFSET;
        c.index = INDEX_W'(ch);
        c.offs  = base;
        issue(c);
        draws = $urandom_range(1, 2);
        repeat (draws) draw_char(ch);
        defined_chars.push_back(ch);
    endtask

    task automatic random_step();
        glyph_cmd_t        c;
        logic [CHAR_W-1:0] ch;
        int                pick;
        bit                run_off;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            run_off = ($urandom_range(0, 24) == 0);
            glyph_seq(run_off ? WALK_MAX : $urandom_range(0, 8), 1'b0, run_off);
        end else if (pick < 68) begin
            move_origin();
        end else if (pick < 85) begin
            if (defined_chars.size() > 0) begin
                ch = defined_chars[$urandom_range(0, defined_chars.size() - 1)];
                if (walk_is_loaded(ch))
                    draw_char(ch);
            end
        end else begin
            // Stray loads: overwrite strokes or offsets out of any sequence.
            c     = noise_cmd();
            c.cmd = ($urandom_range(0, 1) == 0) ? CMD_LOAD_STROKE : CMD_LOAD_OFFSET;
            issue(c);
        end
    endtask

    // Waits until the block has gone quiet; a draw without segments gives no
    // sign of its end, so allow one full walk on top.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge aclk);
        repeat (DRAW_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] sc, logic [CFG_W-1:0] co,
                                logic [CFG_W-1:0] si);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SCALE;
        cfg_wdata <= sc;
        @(posedge aclk);
        cfg_index <= REG_COS;
        cfg_wdata <= co;
        @(posedge aclk);
        cfg_index <= REG_SIN;
        cfg_wdata <= si;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        scale_r = sc;
        cos_r   = co;
        sin_r   = si;
        settings_used++;
    endtask

    always @(posedge aclk) begin : seg_check
        segment_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = '{'{m_from_x, m_from_y, m_to_x, m_to_y}, m_last, m_truncated};
            seg_count++;
            if (m_truncated)
                trunc_seen++;
            if (pending_segs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected segment %h %h -> %h %h last %0b trunc %0b",
                             got.pos.from_x, got.pos.from_y, got.pos.to_x, got.pos.to_y,
                             got.last, got.trunc);
            end else begin
                want = pending_segs.pop_front();
                if (got.pos.from_x !== want.pos.from_x || got.pos.from_y !== want.pos.from_y ||
                    got.pos.to_x !== want.pos.to_x || got.pos.to_y !== want.pos.to_y ||
                    got.last !== want.last || got.trunc !== want.trunc) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("segment %0d: want %h %h -> %h %h last %0b trunc %0b",
                                 seg_count, want.pos.from_x, want.pos.from_y,
                                 want.pos.to_x, want.pos.to_y, want.last, want.trunc);
                        $display("segment %0d: got  %h %h -> %h %h last %0b trunc %0b",
                                 seg_count, got.pos.from_x, got.pos.from_y,
                                 got.pos.to_x, got.pos.to_y, got.last, got.trunc);
                    end
                end
            end
        end
    end

    // Receiver pacing: short random stalls, plus one long hold-off on request.
    initial begin : sink_pacing
        int n;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("stroke_font_glyph_renderer_top_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int goal;
        org_x = '0;
        org_y = '0;
        pen_x = '0;
        pen_y = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        program_regs(SCALE_RESET, COS_RESET, SIN_RESET);
        idle_on = 1'b1;

        foreach (DIRECTED[r])
            issue(DIRECTED[r].c, DIRECTED[r].pinned, DIRECTED[r].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                if (ph == N_PHASES - 1)
                    idle_on = 1'b0;
                case (ph)
                    1: program_regs(16'hFFFF, 16'hC000, 16'h4000);
                    2: program_regs(16'h0000, 16'h4000, 16'hC000);
                    3: program_regs(16'd384, 16'd11585, 16'd11585);
                    4: program_regs(CFG_W'($urandom()), CFG_W'($urandom_range(0, 32768) - 16384),
                                    CFG_W'($urandom_range(0, 32768) - 16384));
                    5: program_regs(16'd1, 16'h8000, 16'h7FFF);
                    default: program_regs(16'd300, 16'd0, 16'd16384);
                endcase
            end
            if (ph == 0)
                glyph_seq(WALK_MAX, 1'b1, 1'b1);
            if (ph == 3) begin
                // Hold the result side while dense glyphs keep arriving.
                hold_req = 1'b1;
                glyph_seq(8, 1'b1, 1'b0);
                glyph_seq(8, 1'b1, 1'b0);
            end
            goal = N_DIRECTED + (ph + 1) * PHASE_ITEMS;
            while (accepted_items - ignored_items < goal)
                random_step();
        end

        settle();
        $display("%0d transactions accepted (%0d ignored), %0d draws, %0d settings",
                 accepted_items, ignored_items, draw_count, settings_used);
        $display("%0d segments checked, %0d truncated, %0d mismatches",
                 seg_count, trunc_seen, mismatches);
        if (mismatches == 0 && pending_segs.size() == 0)
            $display("stroke_font_glyph_renderer_top_tb: done, clean");
        else
            $display("stroke_font_glyph_renderer_top_tb: done, errors");
        $finish;
    end

endmodule
